// ===== hdl/assert_macros.svh =====
// Assertion macros for the element symbol list parser.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

// ===== hdl/esl_pkg.sv =====
// Package for the element symbol list parser: character codes, symbol table,
// token record type and the symbol lookup function. No dependencies.
`default_nettype none

package esl_pkg;

  localparam int NUM_ELEMENTS = 111;
  localparam int TABLE_ELEMENTS = 111;
  localparam int TABLE_CHARS = 2 * TABLE_ELEMENTS;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
  localparam logic [7:0] CHAR_UP_D  = 8'h44;
  localparam logic [7:0] CHAR_UP_L  = 8'h4c;
  localparam logic [7:0] CHAR_LO_P  = 8'h70;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  // symbols of elements 1..111, two characters each, space = no second letter
  localparam logic [8*TABLE_CHARS-1:0] SYM_STR = {
    "H HeLiBeB C N O F NeNaMgAlSiP S ClArK CaScTiV CrMnFeCoNiCu",
    "ZnGaGeAsSeBrKrRbSrY ZrNbMoTcRuRhPdAgCdInSnSbTeI XeCsBaLaCePr",
    "NdPmSmEuGdTbDyHoErTmYbLuHfTaW ReOsIrPtAuHgTlPbBiPoAtRnFrRaAc",
    "ThPaU NpPuAmCmBkCfEsFmMdNoLrRfDbSgBhHsMtDsRg"
  };

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       tok;
    logic       eol;
  } token_t;

  function automatic logic [7:0] sym_char(input int pos);
    logic [7:0] ch;
    ch = SYM_STR[8*(TABLE_CHARS-pos)-1 -: 8];
    return (ch == CHAR_SPACE) ? 8'h00 : ch;
  endfunction

  // symbols are unique, and so is the single-letter element of each letter:
  // the hits are or-ed together
  function automatic logic [7:0] lookup(input logic [7:0] first,
                                        input logic [7:0] second,
                                        input logic [7:0] dflt);
    logic [7:0] exact;
    logic [7:0] single;
    logic       hit_exact;
    logic       hit_single;
    logic [7:0] a;
    logic [7:0] b;
    exact = '0;
    single = '0;
    hit_exact = 1'b0;
    hit_single = 1'b0;
    for (int z = 1; z <= NUM_ELEMENTS && z <= TABLE_ELEMENTS; z++) begin
      a = sym_char(2 * (z - 1));
      b = sym_char(2 * (z - 1) + 1);
      if (first == a && second == b) begin
        exact = exact | 8'(z);
        hit_exact = 1'b1;
      end
      if (first == a && b == 8'h00) begin
        single = single | 8'(z);
        hit_single = 1'b1;
      end
    end
    if (hit_exact) return exact;
    if (hit_single) return single;
    if (first == CHAR_UP_D) return 8'd1;
    if (first == CHAR_UP_L && second == CHAR_LO_P) return 8'd0;
    return dflt;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/element_symbol_list_parser.sv =====
// Element symbol list parser, top level: tokenizer, token record stage and
// lookup/output register. Depends on esl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
//
// Usage
// - Input stream (s_*): one text byte per word. s_tlast marks the end of the
//   text; the byte of that word is ignored.
// - Output stream (m_*): one word per finished token, closed by a separator
//   or by the end marker, and one for a bare end marker. m_tdata is the atomic
//   number, m_tuser says a token's number is carried, m_tlast marks the word
//   caused by the end marker. A bare end marker gives number 0, m_tuser 0.
// - Config (cfg_*): default number for tokens that match nothing. Write it
//   only while the block is idle; cfg_ready is always high.
// - Throughput: one word per cycle in both directions while m_tready is high.
//   From input accept the tokenizer loads a token record; then the 111-entry
//   comparator bank fills the output register, which raises m_tvalid.
// - Stall: while m_tready is low the output register holds and the record
//   stage fills; then s_tready drops. Bytes that give no result still wait
//   for s_tready.
// - Reset (rst, synchronous): token state cleared, pipeline emptied, default
//   number back to 0.
//
module element_symbol_list_parser (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] char_byte
  input  wire        s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] atomic_number
  output logic       m_tuser,   // [0] token_valid
  output logic       m_tlast,   // end_of_list
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [7:0] cfg_data   // [7:0] default_z
);
  import esl_pkg::*;

  // tokenizer state
  logic [7:0] first_letter, first_letter_next;
  logic [7:0] second_letter, second_letter_next;
  logic [1:0] chars_seen, chars_seen_next;
  logic       inside_token, inside_token_next;
  logic [7:0] default_z;

  // token record stage
  token_t     rec, rec_next;
  logic       rec_valid;
  logic       rec_load;

  logic       s_acc;
  logic       out_free;
  logic       is_sep;
  logic       is_up;
  logic       is_lo;
  logic [7:0] c;

  assign cfg_ready = 1'b1;
  assign c         = s_tdata;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !rec_valid || out_free;
  assign s_acc     = s_tvalid && s_tready;

  assign is_sep = (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_SEMI) ||
                  (c == CHAR_TAB) || (c == CHAR_LF);
  assign is_up  = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
  assign is_lo  = (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);

  always_comb begin
    first_letter_next  = first_letter;
    second_letter_next = second_letter;
    chars_seen_next    = chars_seen;
    inside_token_next  = inside_token;
    rec_load           = 1'b0;
    rec_next.first     = first_letter;
    rec_next.second    = second_letter;
    rec_next.tok       = inside_token;
    rec_next.eol       = s_tlast;
    if (s_tlast || is_sep) begin
      // end marker always answers; a separator only closes an open token
      rec_load           = s_tlast || inside_token;
      first_letter_next  = '0;
      second_letter_next = '0;
      chars_seen_next    = '0;
      inside_token_next  = 1'b0;
    end else if (!inside_token) begin
      inside_token_next  = 1'b1;
      first_letter_next  = is_lo ? (c - CASE_DIFF) : c;
      second_letter_next = '0;
      chars_seen_next    = 2'd1;
    end else if (chars_seen == 2'd1) begin
      if (is_up) begin
        second_letter_next = c + CASE_DIFF;
      end else if (is_lo) begin
        second_letter_next = c;
      end else begin
        second_letter_next = '0;
      end
      chars_seen_next = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_letter  <= '0;
      second_letter <= '0;
      chars_seen    <= '0;
      inside_token  <= 1'b0;
    end else if (s_acc) begin
      first_letter  <= first_letter_next;
      second_letter <= second_letter_next;
      chars_seen    <= chars_seen_next;
      inside_token  <= inside_token_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_z <= cfg_data;
    end
  end

  // record stage: refills when it moves on or is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (s_tready) begin
      rec_valid <= s_acc && rec_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_acc && rec_load) begin
      rec <= rec_next;
    end
  end

  // output register: symbol lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && rec_valid) begin
      m_tdata <= rec.tok ? lookup(rec.first, rec.second, default_z) : 8'd0;
      m_tuser <= rec.tok;
      m_tlast <= rec.eol;
    end
  end

  // a word without a token comes from a bare end marker and carries zero
  `ASSERT_IMPL(a_bare_end, m_tvalid && !m_tuser, m_tlast && (m_tdata == 8'd0))
  // end marker always leaves a record behind and closes the token
  `ASSERT_NEXT(a_end_rec, s_acc && s_tlast, rec_valid && rec.eol && !inside_token)
  // chars_seen tracks inside_token
  `ASSERT_IMPL(a_seen, inside_token, (chars_seen == 2'd1) || (chars_seen == 2'd2))
  // a full record stage with a blocked output stops the input
  `ASSERT_IMPL(a_stall, rec_valid && m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire
